// ----- design/huffman_table_segment_builder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Huffman table builder assertion macros
// Shared shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_SEGMENT_BUILDER_UNIT_MACROS_SVH
`define HUFFMAN_TABLE_SEGMENT_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HTSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HTSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/htsb_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman table builder package
// Result status codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package htsb_pkg;

    localparam logic [1:0] STATUS_ENTRY     = 2'd0;
    localparam logic [1:0] STATUS_BAD_CLASS = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

    localparam logic [15:0] CODE_MASK_ALL  = 16'hFFFF;
    localparam logic [15:0] HEADER_BYTES   = 16'd17;
    localparam logic [4:0]  LONGEST_CODE   = 5'd16;

    // Which kind of result the datapath loads into its output register.
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_CLASS_ERR,
        EMIT_LEN_ERR,
        EMIT_ENTRY
    } t_emit;

    typedef struct packed {
        logic  start;     // class/id byte taken: restart all counters
        logic  count;     // count byte taken
        logic  sym_init;  // counts complete and valid: prime the code walk
        logic  sym;       // symbol byte taken: advance code and entry
        logic  walk;      // step over one code length
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cls_bad;     // class nibble of the incoming byte above one
        logic count_last;  // the incoming count byte is the sixteenth
        logic len_bad;     // count sum plus header differs from segment length
        logic total_zero;  // count sum including the incoming byte is zero
        logic is_last;     // the current entry closes the table
        logic walk_step;   // current length is empty and a longer one exists
    } t_dp_status;

endpackage

// ----- design/htsb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Huffman table builder controller
// Tracks the table phase, runs the length walk and owns both handshakes.
// ----------------------------------------------------------------------------
module htsb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_first_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  htsb_pkg::t_dp_status i_stat,
    output htsb_pkg::t_dp_cmd    o_cmd
);
    import htsb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNTS,
        S_SYMBOLS,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_take;

    // An input is taken only outside the walk and when the result slot is
    // free or being emptied in this cycle.
    assign o_ready = (r_state != S_WALK) && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign in_take = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = EMIT_NONE;
        if (in_take && i_first_byte) begin
            o_cmd.start = 1'b1;
            if (i_stat.cls_bad) begin
                o_cmd.emit = EMIT_CLASS_ERR;
                n_state    = S_IDLE;
            end else begin
                n_state = S_COUNTS;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                end
                S_COUNTS: begin
                    if (in_take) begin
                        o_cmd.count = 1'b1;
                        if (i_stat.count_last) begin
                            if (i_stat.len_bad) begin
                                o_cmd.emit = EMIT_LEN_ERR;
                                n_state    = S_IDLE;
                            end else if (i_stat.total_zero) begin
                                n_state = S_IDLE;
                            end else begin
                                o_cmd.sym_init = 1'b1;
                                n_state        = S_WALK;
                            end
                        end
                    end
                end
                S_SYMBOLS: begin
                    if (in_take) begin
                        o_cmd.sym  = 1'b1;
                        o_cmd.emit = EMIT_ENTRY;
                        n_state    = i_stat.is_last ? S_IDLE : S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_stat.walk_step) begin
                        o_cmd.walk = 1'b1;
                    end else begin
                        n_state = S_SYMBOLS;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.emit != EMIT_NONE) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- design/htsb_dp.sv -----
// ----------------------------------------------------------------------------
// Huffman table builder datapath
// Count store, code counters and the registered result fields.
// ----------------------------------------------------------------------------
module htsb_dp #(
    parameter int MAX_CODE_LENGTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  htsb_pkg::t_dp_cmd    i_cmd,
    output htsb_pkg::t_dp_status o_stat,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_segment_length,
    output logic [1:0]           o_status,
    output logic                 o_dht_class,
    output logic [3:0]           o_table_id,
    output logic [11:0]          o_entry_index,
    output logic [7:0]           o_symbol,
    output logic [15:0]          o_code_bits,
    output logic [4:0]           o_code_length,
    output logic [15:0]          o_code_mask,
    output logic                 o_last
);
    import htsb_pkg::*;

    localparam int         IdxW   = $clog2(MAX_CODE_LENGTH);
    localparam logic [4:0] MaxLen = 5'(MAX_CODE_LENGTH);

    logic [7:0]  r_counts [MAX_CODE_LENGTH];
    logic [3:0]  r_cnt_pos;
    logic [11:0] r_total;
    logic [4:0]  r_cur;
    logic [7:0]  r_left;
    logic [15:0] r_next;
    logic [11:0] r_entries;
    logic        r_cls;
    logic [3:0]  r_id;
    logic [15:0] r_seg_len;

    logic        pos_in_range;
    logic [7:0]  count_val;
    logic [11:0] total_next;
    logic [7:0]  walk_count;
    logic [15:0] entry_mask;
    logic [3:0]  mask_shift;

    // Count bytes for lengths beyond the longest code are neither kept nor summed.
    assign pos_in_range = {1'b0, r_cnt_pos} < MaxLen;
    assign count_val    = pos_in_range ? i_data_byte : 8'd0;
    assign total_next   = r_total + {4'd0, count_val};
    assign walk_count   = r_counts[r_cur[IdxW-1:0]];
    assign mask_shift   = 4'(LONGEST_CODE - r_cur);
    assign entry_mask   = CODE_MASK_ALL >> mask_shift;

    assign o_stat.cls_bad    = |i_data_byte[7:5];
    assign o_stat.count_last = (r_cnt_pos == 4'd15);
    assign o_stat.len_bad    = (({4'd0, total_next} + HEADER_BYTES) != r_seg_len);
    assign o_stat.total_zero = (total_next == 12'd0);
    assign o_stat.is_last    = (({1'b0, r_entries} + 13'd1) >= {1'b0, r_total});
    assign o_stat.walk_step  = (r_left == 8'd0) && (r_cur < MaxLen);

    always_ff @(posedge i_clk) begin
        if (i_cmd.count && pos_in_range) begin
            r_counts[r_cnt_pos[IdxW-1:0]] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_pos <= '0;
            r_total   <= '0;
            r_cur     <= 5'd1;
            r_left    <= '0;
            r_next    <= '0;
            r_entries <= '0;
            r_cls     <= 1'b0;
            r_id      <= '0;
            r_seg_len <= '0;
        end else if (i_cmd.start) begin
            r_cnt_pos <= '0;
            r_total   <= '0;
            r_cur     <= 5'd1;
            r_left    <= '0;
            r_next    <= '0;
            r_entries <= '0;
            r_cls     <= i_data_byte[4];
            r_id      <= i_data_byte[3:0];
            r_seg_len <= i_segment_length;
        end else begin
            if (i_cmd.count) begin
                r_cnt_pos <= r_cnt_pos + 4'd1;
                r_total   <= total_next;
            end
            if (i_cmd.sym_init) begin
                r_cur     <= 5'd1;
                r_next    <= '0;
                r_entries <= '0;
                r_left    <= r_counts[0];
            end
            if (i_cmd.sym) begin
                r_entries <= r_entries + 12'd1;
                r_next    <= r_next + 16'd1;
                if (r_left != 8'd0) begin
                    r_left <= r_left - 8'd1;
                end
            end
            if (i_cmd.walk) begin
                r_next <= {r_next[14:0], 1'b0};
                r_cur  <= r_cur + 5'd1;
                r_left <= walk_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            EMIT_CLASS_ERR: begin
                o_status      <= STATUS_BAD_CLASS;
                o_dht_class   <= 1'b0;
                o_table_id    <= i_data_byte[3:0];
                o_entry_index <= '0;
                o_symbol      <= '0;
                o_code_bits   <= '0;
                o_code_length <= '0;
                o_code_mask   <= '0;
                o_last        <= 1'b0;
            end
            EMIT_LEN_ERR: begin
                o_status      <= STATUS_BAD_LEN;
                o_dht_class   <= r_cls;
                o_table_id    <= r_id;
                o_entry_index <= '0;
                o_symbol      <= '0;
                o_code_bits   <= '0;
                o_code_length <= '0;
                o_code_mask   <= '0;
                o_last        <= 1'b0;
            end
            EMIT_ENTRY: begin
                o_status      <= STATUS_ENTRY;
                o_dht_class   <= r_cls;
                o_table_id    <= r_id;
                o_entry_index <= r_entries;
                o_symbol      <= i_data_byte;
                o_code_bits   <= r_next;
                o_code_length <= r_cur;
                o_code_mask   <= entry_mask;
                o_last        <= o_stat.is_last;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- design/huffman_table_segment_builder_unit.sv -----
// ----------------------------------------------------------------------------
// Huffman table segment builder
// Output: a result is registered and shows in the cycle after its byte is taken.
// Throughput: one byte per cycle, except that input pauses for the walk over empty
// code lengths after the sixteenth count byte of a non-empty table of valid length
// and after every symbol byte but the last. A full, stalled result slot holds input.
// Reset: synchronous active-low reset returns the block to idle, output empty.
// ----------------------------------------------------------------------------
module huffman_table_segment_builder_unit #(
    parameter int MAX_CODE_LENGTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_segment_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_dht_class,
    output logic [3:0]  o_table_id,
    output logic [11:0] o_entry_index,
    output logic [7:0]  o_symbol,
    output logic [15:0] o_code_bits,
    output logic [4:0]  o_code_length,
    output logic [15:0] o_code_mask,
    output logic        o_last
);
    import htsb_pkg::*;

    // The controller decides what each transfer means from the table phase
    // and the datapath status; the datapath keeps the counts, the canonical
    // code counters and the result register.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_stat;

    // After the sixteenth count byte of a non-empty table of valid length, and after
    // every entry that is not the last, the controller walks forward over code lengths
    // that hold no codes, doubling the code at each step. Input pauses during the walk.
    htsb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_first_byte (i_first_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd)
    );

    // A result transfer may still be pending while the next input transfer is
    // taken, as long as the result is taken in that same cycle.
    htsb_dp #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_data_byte      (i_data_byte),
        .i_segment_length (i_segment_length),
        .o_status         (o_status),
        .o_dht_class      (o_dht_class),
        .o_table_id       (o_table_id),
        .o_entry_index    (o_entry_index),
        .o_symbol         (o_symbol),
        .o_code_bits      (o_code_bits),
        .o_code_length    (o_code_length),
        .o_code_mask      (o_code_mask),
        .o_last           (o_last)
    );

endmodule

// ----- design/htsb_checker.sv -----
// ----------------------------------------------------------------------------
// Huffman table builder checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "huffman_table_segment_builder_unit_macros.svh"

module htsb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [11:0] o_entry_index,
    input logic [7:0]  o_symbol,
    input logic [15:0] o_code_bits,
    input logic [4:0]  o_code_length,
    input logic [15:0] o_code_mask,
    input logic        o_last
);
    import htsb_pkg::*;

    `HTSB_ASSERT_NOW(a_empty_after_reset, $past(!i_rst_n), !o_valid, "result valid after reset")
    `HTSB_ASSERT_NEXT(a_stall_holds, o_valid && !i_ready, o_valid && $stable(o_symbol) && $stable(o_code_bits), "stalled result changed")
    `HTSB_ASSERT_NOW(a_mask_width, o_valid && o_status == STATUS_ENTRY, $countones(o_code_mask) == 32'(o_code_length) && o_code_length != 5'd0, "mask does not match code length")
    `HTSB_ASSERT_NOW(a_error_clean, o_valid && o_status != STATUS_ENTRY, !o_last && o_entry_index == 12'd0 && o_code_length == 5'd0, "error result carries entry fields")

endmodule

bind huffman_table_segment_builder_unit htsb_checker u_htsb_checker (.*);
